@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error("assertion failed: invariant violated");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check violated");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/b64e_pkg.sv @@
// Types, constants and the alphabet function of the Base64 stream encoder.
package b64e_pkg;

  localparam int JOB_DEPTH_DEF = 2;
  localparam int JOB_CHARS     = 4;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam logic [7:0] UPPER_BASE = 8'h41;
  localparam logic [7:0] LOWER_OFS  = 8'd71;
  localparam logic [7:0] DIGIT_OFS  = 8'd4;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } group_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_beat_t;

  // One byte's worth of characters waiting to be sent.
  typedef struct packed {
    logic [JOB_CHARS-1:0][7:0] chars;
    logic [1:0]                last_idx;
    logic                      fin;
  } job_t;

  typedef struct packed {
    group_phase_t phase;
    logic [3:0]   left;
  } front_stat_t;

  // Maps a sextet to its character of the standard alphabet.
  function automatic logic [7:0] enc(input logic [5:0] s);
    logic [7:0] w;
    logic [7:0] r;
    w = {2'b00, s};
    case (s) inside
      [6'd0:6'd25]:  r = UPPER_BASE + w;
      [6'd26:6'd51]: r = w + LOWER_OFS;
      [6'd52:6'd61]: r = w - DIGIT_OFS;
      6'd62:         r = PLUS_CHAR;
      default:       r = SLASH_CHAR;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/b64e_front.sv @@
// Front end: accepts bytes, tracks the group position and builds character jobs.
module b64e_front import b64e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_beat_t    in_beat,
  input  logic        q_full,
  output logic        q_wr,
  output job_t        q_wdata,
  output front_stat_t stat
);

  group_phase_t phase_r, phase_nxt;
  logic [3:0]   left_r, left_nxt;
  logic [7:0]   b;

  assign b       = in_beat.data_byte;
  assign in_full = q_full;
  assign q_wr    = in_push && !q_full;
  assign stat    = '{phase: phase_r, left: left_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      left_r  <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    q_wdata   = '0;
    q_wdata.fin = in_beat.final_byte;
    case (phase_r)
      PH_SECOND: begin
        q_wdata.chars[0] = enc({left_r[1:0], b[7:4]});
        q_wdata.chars[1] = enc({b[3:0], 2'b00});
        q_wdata.chars[2] = PAD_CHAR;
        q_wdata.chars[3] = PAD_CHAR;
        q_wdata.last_idx = in_beat.final_byte ? 2'd2 : 2'd0;
        if (q_wr) begin
          phase_nxt = PH_THIRD;
          left_nxt  = b[3:0];
        end
      end
      PH_THIRD: begin
        q_wdata.chars[0] = enc({left_r, b[7:6]});
        q_wdata.chars[1] = enc(b[5:0]);
        q_wdata.chars[2] = PAD_CHAR;
        q_wdata.chars[3] = PAD_CHAR;
        q_wdata.last_idx = 2'd1;
        if (q_wr) begin
          phase_nxt = PH_FIRST;
          left_nxt  = 4'd0;
        end
      end
      default: begin
        q_wdata.chars[0] = enc(b[7:2]);
        q_wdata.chars[1] = enc({b[1:0], 4'b0000});
        q_wdata.chars[2] = PAD_CHAR;
        q_wdata.chars[3] = PAD_CHAR;
        q_wdata.last_idx = in_beat.final_byte ? 2'd3 : 2'd0;
        if (q_wr) begin
          phase_nxt = PH_SECOND;
          left_nxt  = {2'b00, b[1:0]};
        end
      end
    endcase
    if (q_wr && in_beat.final_byte) begin
      phase_nxt = PH_FIRST;
      left_nxt  = 4'd0;
    end
  end

endmodule

@@ rtl/b64e_job_fifo.sv @@
// Short job queue between the front end and the character sequencer.
module b64e_job_fifo import b64e_pkg::*; #(
  parameter int DEPTH = JOB_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr,
  input  job_t                       wdata,
  input  logic                       rd,
  output job_t                       rdata,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] cnt
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign cnt   = cnt_r;
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/b64e_back.sv @@
// Back end: steps through each job's characters into the output register.
module b64e_back import b64e_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  job_t      q_rdata,
  output logic      q_rd,
  output logic      out_empty,
  input  logic      out_pop,
  output out_beat_t out_beat
);

  job_t       job_r, job_nxt;
  logic       job_v_r, job_v_nxt;
  logic [1:0] idx_r, idx_nxt;
  out_beat_t  out_r, out_nxt;
  logic       out_v_r, out_v_nxt;
  logic       move, job_done;

  assign out_empty = !out_v_r;
  assign out_beat  = out_r;

  always_comb begin
    move      = job_v_r && (!out_v_r || out_pop);
    job_done  = move && (idx_r == job_r.last_idx);
    q_rd      = !q_empty && (!job_v_r || job_done);
    out_v_nxt = move || (out_v_r && !out_pop);
    out_nxt   = out_r;
    if (move) begin
      out_nxt.out_char  = job_r.chars[idx_r];
      out_nxt.last_char = job_r.fin && (idx_r == job_r.last_idx);
    end
    job_nxt   = job_r;
    job_v_nxt = job_v_r;
    idx_nxt   = idx_r;
    if (q_rd) begin
      job_nxt   = q_rdata;
      job_v_nxt = 1'b1;
      idx_nxt   = 2'd0;
    end else if (job_done) begin
      job_v_nxt = 1'b0;
    end else if (move) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      idx_r   <= 2'd0;
      out_v_r <= 1'b0;
    end else begin
      job_v_r <= job_v_nxt;
      idx_r   <= idx_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    out_r <= out_nxt;
  end

endmodule

@@ rtl/base64_stream_encoder.sv @@
// Top level of the streaming Base64 encoder.
`include "assert_macros.svh"

// Streaming Base64 encoder, standard alphabet with '=' padding. Bytes of a
// message arrive as input beats, the last one flagged by final_byte; the
// encoded characters leave as output beats, one per cycle while popped, with
// last_char set on the final character of each message (after any '='
// padding). The front end takes one byte in every cycle in which the job
// queue has room and turns it into a job of one to four characters; the back
// end sends one character per cycle from the head job while the output is
// popped. The output sets the pace: a plain byte yields one character in the
// first two positions of a three-byte group and two in the third, and a final
// byte up to four for its flush and padding. An accepted byte passes through
// a queue entry, the back end's job register and the output register before
// its first character shows. The queue holds JOB_DEPTH jobs, so the input
// side keeps accepting while a finished character waits to be popped.
module base64_stream_encoder import b64e_pkg::*; #(
  parameter int JOB_DEPTH = JOB_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_beat_t  in_beat,
  output logic      out_empty,
  input  logic      out_pop,
  output out_beat_t out_beat
);

  localparam int CNT_W = $clog2(JOB_DEPTH + 1);

  // Handshake and payload between the front end, the queue and the back end.
  logic             q_wr;
  logic             q_rd;
  logic             q_full;
  logic             q_empty;
  job_t             q_wdata;
  job_t             q_rdata;
  logic [CNT_W-1:0] q_cnt;
  front_stat_t      front_stat;

  // The front end owns the group position and the leftover bits.
  b64e_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_beat (in_beat),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_wdata (q_wdata),
    .stat    (front_stat)
  );

  // The queue lets the front end run ahead while characters drain.
  b64e_job_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty),
    .cnt   (q_cnt)
  );

  // The back end serialises each job into single-character beats.
  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_rd      (q_rd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_beat  (out_beat)
  );

  // At the start of a group no leftover bits may remain.
  `ASSERT_ALWAYS(a_left_clear, clk, rst_n, (front_stat.phase != PH_FIRST) || (front_stat.left == 4'd0))
  // After the first byte of a group only two leftover bits are live.
  `ASSERT_ALWAYS(a_left_two, clk, rst_n, (front_stat.phase != PH_SECOND) || (front_stat.left[3:2] == 2'b00))
  // The back end never takes a job from an empty queue.
  `ASSERT_ALWAYS(a_no_rd_empty, clk, rst_n, !(q_rd && q_empty))
  // A job written without a concurrent read grows the queue by one.
  `ASSERT_NEXT(a_q_grow, clk, rst_n, q_wr && !q_rd, q_cnt == CNT_W'($past(q_cnt) + 1'b1))

endmodule
